[rtl/alle_pkg.sv]
// Shared types and constants for the array linked list engine.
// No dependencies; used by alle_ctrl, array_linked_list_engine and alle_chk.
`timescale 1ns / 1ps

package alle_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int MCNT_W   = 5;
    localparam int MAX_OUT  = 16;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COUNT      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LIST       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FREE,
        ST_START,
        ST_WALK,
        ST_LINK,
        ST_LINK2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] new_value;
    } t_request;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [MCNT_W-1:0]        match_count;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } t_result;

endpackage

[rtl/array_linked_list_engine.sv]
// Top level of the array linked list engine: stream ports, output register,
// value and link RAMs. Depends on alle_pkg, alle_ram and alle_ctrl.
//
//  channel | dir | tdata                                  | tuser      | tlast
//  s_axis  | in  | [31:0] key, [63:32] new_value          | [2:0] mode | -
//  m_axis  | out | [4:0] match_count, [36:5] element,     | [1:0]      | last
//          |     | [39:37] zero                           | status     |
//
// An item is accepted and dispatched; an insert into a list that is not full
// scans for the lowest free slot; on a non-empty list each mode then walks the
// linked slots from the head, followed by the link and result states.
// List mode sends one result per cycle while the sink is ready. Reset is
// synchronous, active low, and leaves the list empty. A stalled sink holds the
// walk; s_axis_tready stays low until the item's last result sits in the
// output register.
`timescale 1ns / 1ps

module array_linked_list_engine #(
    parameter int SLOTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [alle_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // key, new_value
    input  logic [alle_pkg::MODE_W-1:0]     s_axis_tuser,  // mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [alle_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // match_count, element
    output logic [alle_pkg::STATUS_W-1:0]   m_axis_tuser,  // status
    output logic                            m_axis_tlast
);

    localparam int AW = $clog2(SLOTS);
    localparam int IW = $clog2(SLOTS + 1);

    alle_pkg::t_request w_req;
    alle_pkg::t_result  w_res;
    alle_pkg::t_result  r_res;
    logic               r_ovalid;
    logic               w_out_free;
    logic               w_out_load;

    logic                                val_we;
    logic [AW-1:0]                       val_waddr;
    logic signed [alle_pkg::DATA_W-1:0]  val_wdata;
    logic signed [alle_pkg::DATA_W-1:0]  val_rdata;
    logic                                lnk_we;
    logic [AW-1:0]                       lnk_waddr;
    logic [IW-1:0]                       lnk_wdata;
    logic [IW-1:0]                       lnk_rdata;
    logic [AW-1:0]                       rd_addr;

    // mode, key, new_value from the top bit down
    assign w_req = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]};

    assign w_out_free = !r_ovalid || m_axis_tready;

    alle_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (w_req),
        .i_out_free  (w_out_free),
        .o_out_load  (w_out_load),
        .o_out       (w_res),
        .o_val_we    (val_we),
        .o_val_waddr (val_waddr),
        .o_val_wdata (val_wdata),
        .o_lnk_we    (lnk_we),
        .o_lnk_waddr (lnk_waddr),
        .o_lnk_wdata (lnk_wdata),
        .o_rd_addr   (rd_addr),
        .i_val_rdata (val_rdata),
        .i_lnk_rdata (lnk_rdata)
    );

    alle_ram #(
        .WIDTH(alle_pkg::DATA_W),
        .DEPTH(SLOTS)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (rd_addr),
        .o_rdata (val_rdata)
    );

    alle_ram #(
        .WIDTH(IW),
        .DEPTH(SLOTS)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (rd_addr),
        .o_rdata (lnk_rdata)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_res.element, r_res.match_count};
    assign m_axis_tuser  = r_res.status;
    assign m_axis_tlast  = r_res.last;

endmodule

[rtl/alle_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module alle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/alle_ctrl.sv]
// Sequencer of the list engine: free-slot scan, list walk with one shared
// key comparator, link updates. Depends on alle_pkg; drives the two alle_ram.
`timescale 1ns / 1ps

module alle_ctrl #(
    parameter int SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    output logic                             o_req_ready,
    input  alle_pkg::t_request               i_req,
    input  logic                             i_out_free,
    output logic                             o_out_load,
    output alle_pkg::t_result                o_out,
    output logic                             o_val_we,
    output logic [$clog2(SLOTS)-1:0]         o_val_waddr,
    output logic signed [alle_pkg::DATA_W-1:0] o_val_wdata,
    output logic                             o_lnk_we,
    output logic [$clog2(SLOTS)-1:0]         o_lnk_waddr,
    output logic [$clog2(SLOTS+1)-1:0]       o_lnk_wdata,
    output logic [$clog2(SLOTS)-1:0]         o_rd_addr,
    input  logic signed [alle_pkg::DATA_W-1:0] i_val_rdata,
    input  logic [$clog2(SLOTS+1)-1:0]       i_lnk_rdata
);

    localparam int AW = $clog2(SLOTS);
    localparam int IW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] END_MARK = IW'(SLOTS);

    alle_pkg::t_state r_state, n_state;

    logic [alle_pkg::MODE_W-1:0]        r_mode, n_mode;
    logic signed [alle_pkg::DATA_W-1:0] r_key, n_key;
    logic signed [alle_pkg::DATA_W-1:0] r_nv, n_nv;
    logic [SLOTS-1:0] r_used, n_used;
    logic [IW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_scan, n_scan;
    logic [AW-1:0]    r_free, n_free;
    logic [AW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_prev, n_prev;
    logic [IW-1:0]    r_next, n_next;
    logic [IW-1:0]    r_step, n_step;
    logic [IW-1:0]    r_hits, n_hits;
    logic [alle_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic [IW-1:0]    r_res_cnt, n_res_cnt;

    logic            w_ins;
    logic            w_full;
    logic            w_empty;
    logic            w_slot_free;
    logic            w_eq;
    logic            w_last_step;
    logic            w_list_last;
    logic [IW+4:0]   w_res_ext;
    logic [IW+4:0]   w_count_ext;
    logic [IW+4:0]   w_step_ext;

    assign w_ins = (r_mode == alle_pkg::MODE_INS_AFTER) ||
                   (r_mode == alle_pkg::MODE_INS_BEFORE);
    assign w_full      = (r_count == IW'(SLOTS));
    assign w_empty     = (r_count == '0);
    assign w_slot_free = !r_used[r_scan];
    // the shared comparator: stored value against the key
    assign w_eq        = (i_val_rdata == r_key);
    assign w_last_step = (IW'(r_step + IW'(1)) == r_count);
    assign w_step_ext  = {5'b0, r_step};
    assign w_list_last = w_last_step ||
                         (w_step_ext == (IW + 5)'(alle_pkg::MAX_OUT - 1));
    // match_count carries the low five bits of a count
    assign w_res_ext   = {5'b0, r_res_cnt};
    assign w_count_ext = {5'b0, r_count};

    assign o_req_ready = (r_state == alle_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alle_pkg::ST_IDLE;
            r_used  <= '0;
            r_head  <= END_MARK;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_nv         <= n_nv;
        r_scan       <= n_scan;
        r_free       <= n_free;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_next       <= n_next;
        r_step       <= n_step;
        r_hits       <= n_hits;
        r_res_status <= n_res_status;
        r_res_cnt    <= n_res_cnt;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            alle_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = alle_pkg::ST_DISPATCH;
                end
            end
            alle_pkg::ST_DISPATCH: begin
                case (r_mode)
                    alle_pkg::MODE_INS_AFTER, alle_pkg::MODE_INS_BEFORE: begin
                        n_state = w_full ? alle_pkg::ST_OUT : alle_pkg::ST_FREE;
                    end
                    alle_pkg::MODE_DELETE, alle_pkg::MODE_COUNT,
                    alle_pkg::MODE_LIST: begin
                        n_state = w_empty ? alle_pkg::ST_OUT : alle_pkg::ST_START;
                    end
                    default: n_state = alle_pkg::ST_OUT;
                endcase
            end
            alle_pkg::ST_FREE: begin
                if (w_slot_free) begin
                    n_state = w_empty ? alle_pkg::ST_OUT : alle_pkg::ST_START;
                end
            end
            alle_pkg::ST_START: n_state = alle_pkg::ST_WALK;
            alle_pkg::ST_WALK: begin
                case (r_mode)
                    alle_pkg::MODE_INS_AFTER, alle_pkg::MODE_INS_BEFORE,
                    alle_pkg::MODE_DELETE: begin
                        if (w_eq) begin
                            n_state = alle_pkg::ST_LINK;
                        end else if (w_last_step) begin
                            n_state = alle_pkg::ST_OUT;
                        end
                    end
                    alle_pkg::MODE_COUNT: begin
                        if (w_last_step) begin
                            n_state = alle_pkg::ST_OUT;
                        end
                    end
                    alle_pkg::MODE_LIST: begin
                        if (i_out_free && w_list_last) begin
                            n_state = alle_pkg::ST_IDLE;
                        end
                    end
                    default: n_state = alle_pkg::ST_OUT;
                endcase
            end
            alle_pkg::ST_LINK: begin
                case (r_mode)
                    alle_pkg::MODE_INS_AFTER: n_state = alle_pkg::ST_LINK2;
                    alle_pkg::MODE_INS_BEFORE: begin
                        n_state = (r_prev == END_MARK) ? alle_pkg::ST_OUT
                                                       : alle_pkg::ST_LINK2;
                    end
                    default: n_state = alle_pkg::ST_OUT;
                endcase
            end
            alle_pkg::ST_LINK2: n_state = alle_pkg::ST_OUT;
            alle_pkg::ST_OUT: begin
                if (i_out_free) begin
                    n_state = alle_pkg::ST_IDLE;
                end
            end
            default: n_state = alle_pkg::ST_IDLE;
        endcase
    end

    // datapath, memory ports and result load
    always_comb begin
        n_mode       = r_mode;
        n_key        = r_key;
        n_nv         = r_nv;
        n_used       = r_used;
        n_head       = r_head;
        n_count      = r_count;
        n_scan       = r_scan;
        n_free       = r_free;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_next       = r_next;
        n_step       = r_step;
        n_hits       = r_hits;
        n_res_status = r_res_status;
        n_res_cnt    = r_res_cnt;

        o_val_we    = 1'b0;
        o_val_waddr = r_free;
        o_val_wdata = r_nv;
        o_lnk_we    = 1'b0;
        o_lnk_waddr = r_free;
        o_lnk_wdata = r_next;
        o_rd_addr   = r_cur;
        o_out_load  = 1'b0;
        o_out.status      = r_res_status;
        o_out.match_count = w_res_ext[alle_pkg::MCNT_W-1:0];
        o_out.element     = '0;
        o_out.last        = 1'b1;

        case (r_state)
            alle_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_mode = i_req.mode;
                    n_key  = i_req.key;
                    n_nv   = i_req.new_value;
                end
            end
            alle_pkg::ST_DISPATCH: begin
                n_scan = '0;
                if (w_ins) begin
                    n_res_status = alle_pkg::STATUS_FULL;
                    n_res_cnt    = r_count;
                end else if ((r_mode == alle_pkg::MODE_DELETE) ||
                             (r_mode == alle_pkg::MODE_COUNT) ||
                             (r_mode == alle_pkg::MODE_LIST)) begin
                    n_res_status = alle_pkg::STATUS_EMPTY;
                    n_res_cnt    = '0;
                end else begin
                    n_res_status = alle_pkg::STATUS_OK;
                    n_res_cnt    = r_count;
                end
            end
            alle_pkg::ST_FREE: begin
                if (w_slot_free) begin
                    n_free = r_scan;
                    if (w_empty) begin
                        // first element: becomes head, link to end
                        o_val_we     = 1'b1;
                        o_val_waddr  = r_scan;
                        o_lnk_we     = 1'b1;
                        o_lnk_waddr  = r_scan;
                        o_lnk_wdata  = END_MARK;
                        n_used[r_scan] = 1'b1;
                        n_head       = IW'(r_scan);
                        n_count      = IW'(1);
                        n_res_status = alle_pkg::STATUS_OK;
                        n_res_cnt    = IW'(1);
                    end
                end else begin
                    n_scan = AW'(r_scan + AW'(1));
                end
            end
            alle_pkg::ST_START: begin
                o_rd_addr = r_head[AW-1:0];
                n_cur     = r_head[AW-1:0];
                n_prev    = END_MARK;
                n_step    = '0;
                n_hits    = '0;
            end
            alle_pkg::ST_WALK: begin
                case (r_mode)
                    alle_pkg::MODE_INS_AFTER, alle_pkg::MODE_INS_BEFORE,
                    alle_pkg::MODE_DELETE: begin
                        if (w_eq) begin
                            n_next = i_lnk_rdata;
                        end else if (w_last_step) begin
                            n_res_status = alle_pkg::STATUS_NOT_FOUND;
                            n_res_cnt    = r_count;
                        end else begin
                            o_rd_addr = i_lnk_rdata[AW-1:0];
                            n_cur     = i_lnk_rdata[AW-1:0];
                            n_prev    = IW'(r_cur);
                            n_step    = IW'(r_step + IW'(1));
                        end
                    end
                    alle_pkg::MODE_COUNT: begin
                        n_hits = IW'(r_hits + IW'(w_eq));
                        if (w_last_step) begin
                            n_res_status = alle_pkg::STATUS_OK;
                            n_res_cnt    = IW'(r_hits + IW'(w_eq));
                        end else begin
                            o_rd_addr = i_lnk_rdata[AW-1:0];
                            n_cur     = i_lnk_rdata[AW-1:0];
                            n_step    = IW'(r_step + IW'(1));
                        end
                    end
                    alle_pkg::MODE_LIST: begin
                        // stalled sink: re-read the same slot
                        if (i_out_free) begin
                            o_out_load        = 1'b1;
                            o_out.status      = alle_pkg::STATUS_OK;
                            o_out.match_count = w_count_ext[alle_pkg::MCNT_W-1:0];
                            o_out.element     = i_val_rdata;
                            o_out.last        = w_list_last;
                            if (!w_list_last) begin
                                o_rd_addr = i_lnk_rdata[AW-1:0];
                                n_cur     = i_lnk_rdata[AW-1:0];
                                n_step    = IW'(r_step + IW'(1));
                            end
                        end
                    end
                    default: begin
                        n_res_status = alle_pkg::STATUS_OK;
                        n_res_cnt    = r_count;
                    end
                endcase
            end
            alle_pkg::ST_LINK: begin
                case (r_mode)
                    alle_pkg::MODE_INS_AFTER: begin
                        o_val_we     = 1'b1;
                        o_lnk_we     = 1'b1;
                        o_lnk_wdata  = r_next;
                        n_used[r_free] = 1'b1;
                        n_count      = IW'(r_count + IW'(1));
                        n_res_status = alle_pkg::STATUS_OK;
                        n_res_cnt    = IW'(r_count + IW'(1));
                    end
                    alle_pkg::MODE_INS_BEFORE: begin
                        o_val_we     = 1'b1;
                        o_lnk_we     = 1'b1;
                        o_lnk_wdata  = IW'(r_cur);
                        n_used[r_free] = 1'b1;
                        n_count      = IW'(r_count + IW'(1));
                        n_res_status = alle_pkg::STATUS_OK;
                        n_res_cnt    = IW'(r_count + IW'(1));
                        if (r_prev == END_MARK) begin
                            n_head = IW'(r_free);
                        end
                    end
                    default: begin
                        // delete: bypass the matched slot
                        if (r_prev == END_MARK) begin
                            n_head = r_next;
                        end else begin
                            o_lnk_we    = 1'b1;
                            o_lnk_waddr = r_prev[AW-1:0];
                            o_lnk_wdata = r_next;
                        end
                        n_used[r_cur] = 1'b0;
                        n_count      = IW'(r_count - IW'(1));
                        n_res_status = alle_pkg::STATUS_OK;
                        n_res_cnt    = IW'(r_count - IW'(1));
                    end
                endcase
            end
            alle_pkg::ST_LINK2: begin
                o_lnk_we    = 1'b1;
                o_lnk_waddr = (r_mode == alle_pkg::MODE_INS_AFTER) ? r_cur
                                                                   : r_prev[AW-1:0];
                o_lnk_wdata = IW'(r_free);
            end
            alle_pkg::ST_OUT: begin
                o_out_load = i_out_free;
            end
            default: begin
                n_scan = r_scan;
            end
        endcase
    end

endmodule

[rtl/alle_chk.sv]
// Port-level checks for array_linked_list_engine, bound to the top level.
// Depends on alle_pkg for widths and status codes.
`timescale 1ns / 1ps

module alle_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [alle_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [alle_pkg::STATUS_W-1:0]  m_axis_tuser,
    input logic                           m_axis_tlast
);

    // an accepted item blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // error results are single, with a zero element
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != alle_pkg::STATUS_OK)
        |-> m_axis_tlast && (m_axis_tdata[36:5] == '0))
        else $error("error status on a non-final or nonzero result");

    // an empty-list status always reports zero elements
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == alle_pkg::STATUS_EMPTY)
        |-> (m_axis_tdata[4:0] == '0))
        else $error("empty status with nonzero count");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind array_linked_list_engine alle_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
